// ----- src/keypad_code_alarm_controller_unit_assert.svh -----
// ---------------------------------------------------------------------------
// keypad code alarm controller assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ---------------------------------------------------------------------------
`ifndef KEYPAD_CODE_ALARM_CONTROLLER_UNIT_ASSERT_SVH
`define KEYPAD_CODE_ALARM_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define KCAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/kcac_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcac_pkg
// types, codes and constants of the keypad code alarm controller
// ---------------------------------------------------------------------------
package kcac_pkg;

  // number of digits in one code entry
  localparam int CODE_DIGITS = 4;
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [2:0] LAST_SLOT = 3'(CODE_DIGITS - 1);

  // highest keypad digit
  localparam logic [3:0] DIGIT_MAX = 4'd9;
  // saturation value of the wrong-try count
  localparam logic [2:0] TRIES_SAT = 3'd7;
  // limit after reset
  localparam logic [2:0] TRIES_RESET = 3'd3;

  // all sensors idle
  localparam logic [2:0] LEVELS_IDLE = 3'b111;

  // check results
  localparam logic [1:0] CHK_NONE   = 2'd0;
  localparam logic [1:0] CHK_ACCEPT = 2'd1;
  localparam logic [1:0] CHK_REJECT = 2'd2;

  // report causes
  localparam logic [2:0] CAUSE_NONE    = 3'd0;
  localparam logic [2:0] CAUSE_SENSOR1 = 3'd1;
  localparam logic [2:0] CAUSE_SENSOR2 = 3'd2;
  localparam logic [2:0] CAUSE_SENSOR3 = 3'd3;
  localparam logic [2:0] CAUSE_TRIES   = 3'd4;

  // output tdata bit positions used by checks
  localparam int OUT_MODE_LSB   = 0;
  localparam int OUT_SOUND_BIT  = 2;
  localparam int OUT_HELD_LSB   = 3;
  localparam int OUT_TRIES_LSB  = 6;
  localparam int OUT_CHECK_LSB  = 9;
  localparam int OUT_CAUSE_LSB  = 11;

  typedef enum logic [1:0] {
    MODE_LOCKED  = 2'd0,
    MODE_MENU    = 2'd1,
    MODE_ARMED   = 2'd2,
    MODE_NEWCODE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_DIGIT = 3'd0,
    ACT_ARM   = 3'd1,
    ACT_EDIT  = 3'd2,
    ACT_SENSE = 3'd3,
    ACT_LOCK  = 3'd4
  } action_t;

  // event payload, lowest field in the lowest bits
  typedef struct packed {
    logic [5:0] now_second;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [6:0] now_year;
    logic [3:0] now_month;
    logic [4:0] now_day;
    logic [2:0] sensor_levels;
    logic [3:0] digit;
  } event_data_t;

  typedef struct packed {
    action_t     action;
    event_data_t data;
  } event_t;

  // result item, lowest field in the lowest bits
  typedef struct packed {
    logic [5:0] report_second;
    logic [5:0] report_minute;
    logic [4:0] report_hour;
    logic [6:0] report_year;
    logic [3:0] report_month;
    logic [4:0] report_day;
    logic [2:0] report_cause;
    logic [1:0] check_result;
    logic [2:0] tries_now;
    logic [2:0] digits_held;
    logic       sounding;
    logic [1:0] mode_now;
  } result_t;

  // handshake status between input and output stages
  typedef struct packed {
    logic step;
  } flow_t;

  // stored code after reset: 1, 2, 3, 4 then zeros
  function automatic logic [3:0] reset_code_digit(input int i);
    logic [3:0] d;
    d = (i < 4) ? 4'(i + 1) : 4'd0;
    return d;
  endfunction

endpackage

// ----- src/keypad_code_alarm_controller_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keypad_code_alarm_controller_unit
// keypad code lock and alarm controller with timestamped alarm reports
// ---------------------------------------------------------------------------
// Events arrive on the s_axis stream: tuser carries the action code, tdata
// the digit, the sensor levels and the current date and time. Every event
// gives exactly one result on the m_axis stream: mode, alarm flag, entry
// count, wrong-try count, check result and the cause and time of the last
// report. The wrong-try limit is written through cfg_we / cfg_wdata; the user
// must write it only while no event is in flight, the block does not enforce it.
// An accepted event passes through the input register, then the state update and
// the result register, which take it together.
// Throughput is one event per cycle while m_axis_tready stays high; the update
// loop is not pipelined, so back-to-back events see the state of the one before.
// Reset clears the mode to locked, the alarm, the counters and the report,
// restores the code 1234 and sets the limit to 3. When the receiver holds
// m_axis_tready low the result stays put, one more event waits in the input
// register, and s_axis_tready drops until the result transfers.
// ---------------------------------------------------------------------------
`include "keypad_code_alarm_controller_unit_assert.svh"

module keypad_code_alarm_controller_unit import kcac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // digit[3:0], sensor_levels[6:4], now_day[11:7], now_month[15:12],
  // now_year[22:16], now_hour[27:23], now_minute[33:28], now_second[39:34]
  input  logic [39:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mode_now[1:0], sounding[2], digits_held[5:3], tries_now[8:6],
  // check_result[10:9], report_cause[13:11], report_day[18:14],
  // report_month[22:19], report_year[29:23], report_hour[34:30],
  // report_minute[40:35], report_second[46:41], zero[47]
  output logic [47:0] m_axis_tdata
);

  event_t  s_event;
  event_t  held;
  flow_t   flow;
  logic    out_free;
  result_t core_result;
  result_t m_result;

  // unpack the incoming transfer
  assign s_event.action = action_t'(s_axis_tuser);
  assign s_event.data   = s_axis_tdata;

  kcac_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_event  (s_event),
    .out_free (out_free),
    .flow     (flow),
    .held     (held)
  );

  kcac_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .flow      (flow),
    .ev        (held),
    .result    (core_result)
  );

  kcac_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .step      (flow.step),
    .result_in (core_result),
    .out_free  (out_free),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_result  (m_result)
  );

  // pack the result with a zero pad bit on top
  assign m_axis_tdata = {1'b0, m_result};

  // input side stalls only behind a stalled, occupied result slot
  `KCAC_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output stall")
  // entry count stays below a full entry
  `KCAC_ASSERT_NOW(a_held_range, m_axis_tvalid, m_axis_tdata[OUT_HELD_LSB +: 3] <= LAST_SLOT, "digits_held out of range")
  // an accepted code leaves the menu open, the alarm quiet and tries cleared
  `KCAC_ASSERT_NOW(a_accept_state, m_axis_tvalid && m_axis_tdata[OUT_CHECK_LSB +: 2] == CHK_ACCEPT, m_axis_tdata[OUT_MODE_LSB +: 2] == MODE_MENU && !m_axis_tdata[OUT_SOUND_BIT] && m_axis_tdata[OUT_TRIES_LSB +: 3] == 3'd0, "accepted code with wrong state")
  // a sounding alarm always has a recorded cause
  `KCAC_ASSERT_NOW(a_sound_cause, m_axis_tvalid && m_axis_tdata[OUT_SOUND_BIT], m_axis_tdata[OUT_CAUSE_LSB +: 3] != CAUSE_NONE, "alarm without cause")

endmodule

// ----- src/kcac_in_stage.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcac_in_stage
// input register of the event stream, released when the result slot is free
// ---------------------------------------------------------------------------
module kcac_in_stage import kcac_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   s_valid,
  output logic   s_ready,
  input  event_t s_event,
  input  logic   out_free,
  output flow_t  flow,
  output event_t held
);

  logic in_valid;

  // event moves into the core when the result slot can take it
  assign flow.step     = in_valid & out_free;
  assign s_ready       = ~in_valid | out_free;

  // occupancy and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      in_valid <= 1'b1;
    end else if (flow.step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      held <= s_event;
    end
  end

endmodule

// ----- src/kcac_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcac_core
// controller state and the next-state update for one event
// ---------------------------------------------------------------------------
module kcac_core import kcac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  input  flow_t      flow,
  input  event_t     ev,
  output result_t    result
);

  logic [2:0] max_tries;
  mode_t      mode;
  logic       sounding;
  logic [2:0] entry_count;
  logic [2:0] wrong_count;
  logic [2:0] cause;
  logic [4:0] rep_day;
  logic [3:0] rep_month;
  logic [6:0] rep_year;
  logic [4:0] rep_hour;
  logic [5:0] rep_minute;
  logic [5:0] rep_second;
  logic [3:0] entry_digits [CODE_DIGITS];
  logic [3:0] stored_code  [CODE_DIGITS];

  mode_t      mode_next;
  logic       sounding_next;
  logic [2:0] entry_count_next;
  logic [2:0] wrong_count_next;
  logic       take_report;
  logic [2:0] cause_next;
  logic [1:0] check;
  logic       entry_we;
  logic       code_we;
  logic [3:0] full_entry [CODE_DIGITS];
  logic       match;
  logic [2:0] tries_inc;
  logic [IDX_W-1:0] slot;

  assign slot = entry_count[IDX_W-1:0];

  // complete entry with the incoming digit in the last slot
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      full_entry[i] = (i == CODE_DIGITS - 1) ? ev.data.digit : entry_digits[i];
      if (full_entry[i] != stored_code[i]) begin
        match = 1'b0;
      end
    end
  end

  assign tries_inc = (wrong_count != TRIES_SAT) ? 3'(wrong_count + 3'd1) : wrong_count;

  // event decode and next state
  always_comb begin
    mode_next        = mode;
    sounding_next    = sounding;
    entry_count_next = entry_count;
    wrong_count_next = wrong_count;
    take_report      = 1'b0;
    cause_next       = cause;
    check            = CHK_NONE;
    entry_we         = 1'b0;
    code_we          = 1'b0;
    case (ev.action)
      ACT_DIGIT: begin
        if (ev.data.digit <= DIGIT_MAX && mode != MODE_MENU) begin
          entry_we = 1'b1;
          if (entry_count == LAST_SLOT) begin
            entry_count_next = 3'd0;
            if (mode == MODE_NEWCODE) begin
              code_we   = 1'b1;
              mode_next = MODE_MENU;
            end else if (match) begin
              check            = CHK_ACCEPT;
              wrong_count_next = 3'd0;
              sounding_next    = 1'b0;
              mode_next        = MODE_MENU;
            end else begin
              check            = CHK_REJECT;
              wrong_count_next = tries_inc;
              if (tries_inc >= max_tries) begin
                sounding_next = 1'b1;
                take_report   = 1'b1;
                cause_next    = CAUSE_TRIES;
                if (mode == MODE_LOCKED) begin
                  mode_next        = MODE_ARMED;
                  wrong_count_next = 3'd0;
                end
              end
            end
          end else begin
            entry_count_next = 3'(entry_count + 3'd1);
          end
        end
      end
      ACT_ARM: begin
        if (mode == MODE_MENU) begin
          mode_next        = MODE_ARMED;
          entry_count_next = 3'd0;
          wrong_count_next = 3'd0;
        end
      end
      ACT_EDIT: begin
        if (mode == MODE_MENU) begin
          mode_next        = MODE_NEWCODE;
          entry_count_next = 3'd0;
        end
      end
      ACT_SENSE: begin
        if (mode == MODE_ARMED && ev.data.sensor_levels != LEVELS_IDLE) begin
          sounding_next = 1'b1;
          take_report   = 1'b1;
          if (!ev.data.sensor_levels[2]) begin
            cause_next = CAUSE_SENSOR3;
          end else if (!ev.data.sensor_levels[1]) begin
            cause_next = CAUSE_SENSOR2;
          end else begin
            cause_next = CAUSE_SENSOR1;
          end
        end
      end
      ACT_LOCK: begin
        if (mode == MODE_MENU) begin
          mode_next        = MODE_LOCKED;
          entry_count_next = 3'd0;
        end else if (mode == MODE_NEWCODE) begin
          mode_next        = MODE_MENU;
          entry_count_next = 3'd0;
        end else if (mode == MODE_LOCKED) begin
          entry_count_next = 3'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // result fields show the state after this event
  always_comb begin
    result.mode_now      = mode_next;
    result.sounding      = sounding_next;
    result.digits_held   = entry_count_next;
    result.tries_now     = wrong_count_next;
    result.check_result  = check;
    result.report_cause  = cause_next;
    result.report_day    = take_report ? ev.data.now_day    : rep_day;
    result.report_month  = take_report ? ev.data.now_month  : rep_month;
    result.report_year   = take_report ? ev.data.now_year   : rep_year;
    result.report_hour   = take_report ? ev.data.now_hour   : rep_hour;
    result.report_minute = take_report ? ev.data.now_minute : rep_minute;
    result.report_second = take_report ? ev.data.now_second : rep_second;
  end

  // control state, limit register and stored code
  always_ff @(posedge clk) begin
    if (rst) begin
      max_tries   <= TRIES_RESET;
      mode        <= MODE_LOCKED;
      sounding    <= 1'b0;
      entry_count <= 3'd0;
      wrong_count <= 3'd0;
      cause       <= CAUSE_NONE;
      rep_day     <= '0;
      rep_month   <= '0;
      rep_year    <= '0;
      rep_hour    <= '0;
      rep_minute  <= '0;
      rep_second  <= '0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_code[i] <= reset_code_digit(i);
      end
    end else begin
      if (cfg_we) begin
        max_tries <= cfg_wdata;
      end
      if (flow.step) begin
        mode        <= mode_next;
        sounding    <= sounding_next;
        entry_count <= entry_count_next;
        wrong_count <= wrong_count_next;
        cause       <= cause_next;
        rep_day     <= result.report_day;
        rep_month   <= result.report_month;
        rep_year    <= result.report_year;
        rep_hour    <= result.report_hour;
        rep_minute  <= result.report_minute;
        rep_second  <= result.report_second;
        if (code_we) begin
          for (int i = 0; i < CODE_DIGITS; i++) begin
            stored_code[i] <= full_entry[i];
          end
        end
      end
    end
  end

  // entry buffer, valid only once a full entry has been keyed
  always_ff @(posedge clk) begin
    if (flow.step && entry_we) begin
      entry_digits[slot] <= ev.data.digit;
    end
  end

endmodule

// ----- src/kcac_out_stage.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kcac_out_stage
// result register holding one result until the receiver takes it
// ---------------------------------------------------------------------------
module kcac_out_stage import kcac_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  result_t result_in,
  output logic    out_free,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_result
);

  // slot is free when empty or emptied by a transfer this cycle
  assign out_free = ~m_valid | m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (step) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_result <= result_in;
    end
  end

endmodule

// ----- tb/sv/keypad_alarm_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keypad_alarm_checker
// watches the event, result and limit channels of the alarm controller
// ---------------------------------------------------------------------------
// Every event transfer is run through a local model of the keypad lock (mode,
// entry buffer, stored code, wrong-try count, alarm flag and last report) and
// the status it should produce is queued. Every result transfer is compared
// field by field with the oldest queued status. Writes of the wrong-try limit
// are tracked from the cfg port. The model state is also handed out as hints
// so the stimulus side can steer its key sequences.
// ---------------------------------------------------------------------------
module keypad_alarm_checker import kcac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // digit[3:0], sensor_levels[6:4], now_day[11:7], now_month[15:12],
  // now_year[22:16], now_hour[27:23], now_minute[33:28], now_second[39:34]
  input  logic [39:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mode_now[1:0], sounding[2], digits_held[5:3], tries_now[8:6],
  // check_result[10:9], report_cause[13:11], report_day[18:14],
  // report_month[22:19], report_year[29:23], report_hour[34:30],
  // report_minute[40:35], report_second[46:41], zero[47]
  input  logic [47:0] m_axis_tdata,
  output int          fail_count,
  output int          pending,
  output mode_t       mode_hint,
  output logic [2:0]  held_hint,
  output logic [4*CODE_DIGITS-1:0] code_hint
);

  localparam int PRINT_CAP = 40;

  // model of the lock
  logic [2:0]  limit_q;
  mode_t       mode_q;
  logic        sound_q;
  logic [3:0]  entry_buf [CODE_DIGITS];
  logic [2:0]  held_q;
  logic [2:0]  wrong_q;
  logic [3:0]  code_q [CODE_DIGITS];
  logic [2:0]  cause_q;
  event_data_t stamp_q;

  result_t awaited_status [$];
  int      results_seen = 0;

  initial fail_count = 0;
  initial pending = 0;

  // one line per mismatch, output bounded
  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [6:0] got,
                             input logic [6:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_seen, name, got, want));
  endtask

  // apply one event to the lock model and build the status it yields
  task automatic advance_keypad(input logic [2:0] act, input event_data_t ev,
                                output result_t status);
    logic [1:0] check;
    logic       same;
    int         count;
    int         i;
    check = CHK_NONE;
    case (act)
      ACT_DIGIT: begin
        if (ev.digit <= DIGIT_MAX && mode_q != MODE_MENU) begin
          entry_buf[held_q[IDX_W-1:0]] = ev.digit;
          count = int'(held_q) + 1;
          if (count < CODE_DIGITS) begin
            held_q = 3'(count);
          end else begin
            held_q = '0;
            if (mode_q == MODE_NEWCODE) begin
              // full entry becomes the new code
              for (i = 0; i < CODE_DIGITS; i++) code_q[i] = entry_buf[i];
              mode_q = MODE_MENU;
            end else begin
              same = 1'b1;
              for (i = 0; i < CODE_DIGITS; i++)
                if (entry_buf[i] != code_q[i]) same = 1'b0;
              if (same) begin
                check   = CHK_ACCEPT;
                wrong_q = '0;
                sound_q = 1'b0;
                mode_q  = MODE_MENU;
              end else begin
                check = CHK_REJECT;
                if (wrong_q < TRIES_SAT) wrong_q = wrong_q + 3'd1;
                // too many tries starts the alarm
                if (wrong_q >= limit_q) begin
                  sound_q = 1'b1;
                  cause_q = CAUSE_TRIES;
                  stamp_q = ev;
                  if (mode_q == MODE_LOCKED) begin
                    mode_q  = MODE_ARMED;
                    wrong_q = '0;
                  end
                end
              end
            end
          end
        end
      end
      ACT_ARM: begin
        if (mode_q == MODE_MENU) begin
          mode_q  = MODE_ARMED;
          held_q  = '0;
          wrong_q = '0;
        end
      end
      ACT_EDIT: begin
        if (mode_q == MODE_MENU) begin
          mode_q = MODE_NEWCODE;
          held_q = '0;
        end
      end
      ACT_SENSE: begin
        // highest tripped sensor wins
        if (mode_q == MODE_ARMED && ev.sensor_levels != LEVELS_IDLE) begin
          sound_q = 1'b1;
          stamp_q = ev;
          if (!ev.sensor_levels[2])      cause_q = CAUSE_SENSOR3;
          else if (!ev.sensor_levels[1]) cause_q = CAUSE_SENSOR2;
          else                           cause_q = CAUSE_SENSOR1;
        end
      end
      ACT_LOCK: begin
        case (mode_q)
          MODE_MENU: begin
            mode_q = MODE_LOCKED;
            held_q = '0;
          end
          MODE_NEWCODE: begin
            mode_q = MODE_MENU;
            held_q = '0;
          end
          MODE_LOCKED: held_q = '0;
          default: ;
        endcase
      end
      default: ;
    endcase
    status               = '0;
    status.mode_now      = mode_q;
    status.sounding      = sound_q;
    status.digits_held   = held_q;
    status.tries_now     = wrong_q;
    status.check_result  = check;
    status.report_cause  = cause_q;
    status.report_day    = stamp_q.now_day;
    status.report_month  = stamp_q.now_month;
    status.report_year   = stamp_q.now_year;
    status.report_hour   = stamp_q.now_hour;
    status.report_minute = stamp_q.now_minute;
    status.report_second = stamp_q.now_second;
  endtask

  // channel monitor: results are matched before new events are queued
  always @(posedge clk) begin
    result_t got;
    result_t want;
    int      i;
    if (rst) begin
      limit_q = TRIES_RESET;
      mode_q  = MODE_LOCKED;
      sound_q = 1'b0;
      held_q  = '0;
      wrong_q = '0;
      cause_q = CAUSE_NONE;
      stamp_q = '0;
      for (i = 0; i < CODE_DIGITS; i++) begin
        entry_buf[i] = '0;
        code_q[i]    = reset_code_digit(i);
      end
      awaited_status.delete();
    end else begin
      if (cfg_we) limit_q = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[46:0]);
        if (awaited_status.size() == 0) begin
          report_mismatch($sformatf("result %0d with no event waiting",
                                    results_seen));
        end else begin
          want = awaited_status.pop_front();
          check_field("mode_now",      got.mode_now,      want.mode_now);
          check_field("sounding",      got.sounding,      want.sounding);
          check_field("digits_held",   got.digits_held,   want.digits_held);
          check_field("tries_now",     got.tries_now,     want.tries_now);
          check_field("check_result",  got.check_result,  want.check_result);
          check_field("report_cause",  got.report_cause,  want.report_cause);
          check_field("report_day",    got.report_day,    want.report_day);
          check_field("report_month",  got.report_month,  want.report_month);
          check_field("report_year",   got.report_year,   want.report_year);
          check_field("report_hour",   got.report_hour,   want.report_hour);
          check_field("report_minute", got.report_minute, want.report_minute);
          check_field("report_second", got.report_second, want.report_second);
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_keypad(s_axis_tuser, event_data_t'(s_axis_tdata), want);
        awaited_status.push_back(want);
      end
    end
    // registered view for the stimulus side
    pending   <= awaited_status.size();
    mode_hint <= mode_q;
    held_hint <= held_q;
    for (i = 0; i < CODE_DIGITS; i++) code_hint[4*i +: 4] <= code_q[i];
  end

endmodule

// ----- tb/sv/tb_keypad_code_alarm_controller_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_keypad_code_alarm_controller_unit
// stimulus and verdict for the keypad code alarm controller
// ---------------------------------------------------------------------------
// A short directed run covers ignored keys, wrong entries up to the alarm,
// sensor priority, unlock while armed, edit, abort and arm. Then random key
// sequences run under several wrong-try limits: unlock, arm and watch the
// sensors, change the code, wrong tries from locked, aborted edits and pure
// noise. Both stream sides idle at random, apart from one steady stretch.
// The checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_keypad_code_alarm_controller_unit import kcac_pkg::*;;

  localparam int         IDLE_PCT     = 11;
  localparam int         ITEMS_TOTAL  = 700;
  localparam int         PHASES       = 6;
  localparam int         STEADY_LEN   = 150;
  localparam int         PIPE_LATENCY = 2;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam logic [2:0] ACT_FIELD_TOP   = 3'd7;
  localparam logic [3:0] DIGIT_FIELD_TOP = 4'd15;

  typedef enum logic [2:0] {
    SC_ARM_WATCH,
    SC_NEW_CODE,
    SC_LOCKED_TRIES,
    SC_ABORT,
    SC_NOISE
  } scenario_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  int          fail_count;
  int          pending;
  mode_t       mode_hint;
  logic [2:0]  held_hint;
  logic [4*CODE_DIGITS-1:0] code_hint;

  int          real_sent = 0;
  int          stretch_lo = 0;
  bit          steady = 1'b0;
  int          cycle_count = 0;
  logic [2:0]  phase_limit [PHASES] = '{3'd7, 3'd1, 3'd0, 3'd5, 3'd2, 3'd4};

  keypad_code_alarm_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  keypad_alarm_checker status_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .mode_hint     (mode_hint),
    .held_hint     (held_hint),
    .code_hint     (code_hint)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk)
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

  // random date and time within the clock ranges
  function automatic event_data_t stamped(input logic [3:0] dig,
                                          input logic [2:0] lv);
    event_data_t ev;
    ev.digit         = dig;
    ev.sensor_levels = lv;
    ev.now_day       = 5'($urandom_range(1, 31));
    ev.now_month     = 4'($urandom_range(1, 12));
    ev.now_year      = 7'($urandom_range(0, 99));
    ev.now_hour      = 5'($urandom_range(0, 23));
    ev.now_minute    = 6'($urandom_range(0, 59));
    ev.now_second    = 6'($urandom_range(0, 59));
    return ev;
  endfunction

  // earliest or latest possible date and time
  function automatic event_data_t stamp_edge(input bit top_end,
                                             input logic [3:0] dig,
                                             input logic [2:0] lv);
    event_data_t ev;
    ev.digit         = dig;
    ev.sensor_levels = lv;
    ev.now_day       = top_end ? 5'd31 : 5'd1;
    ev.now_month     = top_end ? 4'd12 : 4'd1;
    ev.now_year      = top_end ? 7'd99 : 7'd0;
    ev.now_hour      = top_end ? 5'd23 : 5'd0;
    ev.now_minute    = top_end ? 6'd59 : 6'd0;
    ev.now_second    = top_end ? 6'd59 : 6'd0;
    return ev;
  endfunction

  // one event transfer, with random gaps ahead of it
  task automatic send_event(input logic [2:0] act, input event_data_t ev,
                            input bit counted);
    steady = (real_sent >= stretch_lo) && (real_sent < stretch_lo + STEADY_LEN);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= ev;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (counted) real_sent++;
  endtask

  task automatic press(input logic [3:0] dig);
    send_event(ACT_DIGIT, stamped(dig, LEVELS_IDLE), 1'b1);
  endtask

  task automatic command(input logic [2:0] act);
    send_event(act, stamped(4'($urandom_range(0, DIGIT_MAX)), LEVELS_IDLE), 1'b1);
  endtask

  // full code entry, now and then with a dead key in between
  task automatic key_code(input logic [4*CODE_DIGITS-1:0] code);
    int i;
    for (i = 0; i < CODE_DIGITS; i++) begin
      if ($urandom_range(0, 99) < 6)
        send_event(ACT_DIGIT,
                   stamped(4'($urandom_range(DIGIT_MAX + 1, DIGIT_FIELD_TOP)),
                           LEVELS_IDLE), 1'b0);
      press(code[4*i +: 4]);
    end
  endtask

  task automatic wrong_entry();
    int i;
    for (i = 0; i < CODE_DIGITS; i++) press(4'($urandom_range(0, DIGIT_MAX)));
  endtask

  // event that leaves every mode unchanged, so the hints catch up with it
  task automatic settle_item();
    case ($urandom_range(0, 2))
      0: send_event(ACT_SENSE, stamped(4'd0, LEVELS_IDLE), 1'b0);
      1: send_event(ACT_DIGIT,
                    stamped(4'($urandom_range(DIGIT_MAX + 1, DIGIT_FIELD_TOP)),
                            3'($urandom_range(0, 7))), 1'b0);
      default: send_event(3'($urandom_range(ACT_LOCK + 1, ACT_FIELD_TOP)),
                          stamped(4'($urandom_range(0, DIGIT_FIELD_TOP)),
                                  3'($urandom_range(0, 7))), 1'b0);
    endcase
  endtask

  // limit write with no event in flight
  task automatic write_limit(input logic [2:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // bring the lock to the menu from whatever mode it is in
  task automatic reach_menu();
    int i;
    case (mode_hint)
      MODE_NEWCODE: command(ACT_LOCK);
      MODE_LOCKED: begin
        if (held_hint != 0) command(ACT_LOCK);
        key_code(code_hint);
      end
      MODE_ARMED: begin
        for (i = int'(held_hint); i < CODE_DIGITS; i++)
          press(4'($urandom_range(0, DIGIT_MAX)));
        key_code(code_hint);
      end
      default: ;
    endcase
  endtask

  // one key sequence starting from the menu
  task automatic run_scenario();
    scenario_t pick;
    int        roll;
    int        n;
    int        i;
    logic [4*CODE_DIGITS-1:0] fresh;
    logic [2:0] lv;
    reach_menu();
    roll = $urandom_range(0, 99);
    if (roll < 25)      pick = SC_ARM_WATCH;
    else if (roll < 45) pick = SC_NEW_CODE;
    else if (roll < 72) pick = SC_LOCKED_TRIES;
    else if (roll < 86) pick = SC_ABORT;
    else                pick = SC_NOISE;
    case (pick)
      SC_ARM_WATCH: begin
        command(ACT_ARM);
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) begin
          lv = ($urandom_range(0, 1) != 0) ? LEVELS_IDLE : 3'($urandom_range(0, 7));
          send_event(ACT_SENSE, stamped(4'($urandom_range(0, DIGIT_MAX)), lv), 1'b1);
        end
        // a few misses, sometimes enough to saturate the count
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 2);
        for (i = 0; i < n; i++) wrong_entry();
        if ($urandom_range(0, 3) == 0) command(ACT_LOCK);
        key_code(code_hint);
      end
      SC_NEW_CODE: begin
        command(ACT_EDIT);
        for (i = 0; i < CODE_DIGITS; i++)
          fresh[4*i +: 4] = 4'($urandom_range(0, DIGIT_MAX));
        key_code(fresh);
      end
      SC_LOCKED_TRIES: begin
        command(ACT_LOCK);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++) wrong_entry();
        key_code(code_hint);
      end
      SC_ABORT: begin
        // partial entries thrown away by back/lock
        command(($urandom_range(0, 1) != 0) ? ACT_EDIT : ACT_LOCK);
        n = $urandom_range(1, CODE_DIGITS - 1);
        for (i = 0; i < n; i++) press(4'($urandom_range(0, DIGIT_MAX)));
        if ($urandom_range(0, 1) != 0) command(ACT_ARM);
        command(ACT_LOCK);
      end
      default: begin
        n = $urandom_range(3, 8);
        for (i = 0; i < n; i++)
          send_event(3'($urandom_range(0, ACT_FIELD_TOP)),
                     stamped(4'($urandom_range(0, DIGIT_FIELD_TOP)),
                             3'($urandom_range(0, 7))), 1'b1);
      end
    endcase
    settle_item();
  endtask

  // main sequence
  initial begin
    int p;
    int goal;
    stretch_lo = $urandom_range(100, 450);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // dead key, then three misses reach the reset limit
    send_event(ACT_DIGIT, stamp_edge(1'b0, DIGIT_FIELD_TOP, LEVELS_IDLE), 1'b1);
    key_code('0);
    key_code({4'd0, 4'd9, 4'd0, 4'd9});
    press(4'd5);
    press(4'd6);
    press(4'd7);
    send_event(ACT_DIGIT, stamp_edge(1'b1, 4'd8, LEVELS_IDLE), 1'b1);
    // sensor priority while armed
    send_event(ACT_SENSE, stamp_edge(1'b0, 4'd0, 3'b110), 1'b1);
    send_event(ACT_SENSE, stamped(4'd0, 3'b100), 1'b1);
    send_event(ACT_SENSE, stamp_edge(1'b1, 4'd0, 3'b010), 1'b1);
    command(ACT_LOCK);
    // correct code silences the alarm
    key_code({4'd4, 4'd3, 4'd2, 4'd1});
    command(ACT_EDIT);
    press(4'd9);
    press(4'd0);
    press(4'd9);
    command(ACT_LOCK);
    command(ACT_ARM);
    settle_item();

    // random sequences under each limit
    for (p = 0; p < PHASES; p++) begin
      write_limit(phase_limit[p]);
      goal = real_sent + ITEMS_TOTAL / PHASES;
      while (real_sent < goal) run_scenario();
    end

    // drain
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- keypad_code_alarm_controller_unit.f -----
+incdir+src
src/kcac_pkg.sv
src/kcac_in_stage.sv
src/kcac_core.sv
src/kcac_out_stage.sv
src/keypad_code_alarm_controller_unit.sv
tb/sv/keypad_alarm_checker.sv
tb/sv/tb_keypad_code_alarm_controller_unit.sv
